@@ rtl/ple_pkg.sv @@
// Shared constants, widths and operation codes of the positional list engine.
package ple_pkg;

	// Capacity of the list.
	localparam int LIST_DEPTH = 16;

	// Item and field widths.
	localparam int DATA_W    = 32;
	localparam int POS_W     = 5;
	localparam int CNT_OUT_W = 5;

	// Internal widths that follow from the capacity.
	localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CNT_W = $clog2(LIST_DEPTH + 1);
	localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	// Requested operation.
	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_REMOVE = 1'b1;

endpackage

@@ rtl/ple_req_if.sv @@
// Request channel: operation, position and value with a valid/ready handshake.
interface ple_req_if;
	logic                               valid;
	logic                               ready;
	logic                               func;
	logic        [ple_pkg::POS_W-1:0]   position;
	logic signed [ple_pkg::DATA_W-1:0]  value;

	modport source (output valid, func, position, value, input ready);
	modport sink   (input valid, func, position, value, output ready);
endinterface

@@ rtl/ple_rsp_if.sv @@
// Result channel: list status after each request with a valid/ready handshake.
interface ple_rsp_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 accepted;
	logic        [ple_pkg::CNT_OUT_W-1:0] item_count;
	logic                                 list_empty;
	logic signed [ple_pkg::DATA_W-1:0]    last_item;
	logic signed [ple_pkg::DATA_W-1:0]    total_sum;

	modport source (output valid, accepted, item_count, list_empty, last_item, total_sum,
		input ready);
	modport sink   (input valid, accepted, item_count, list_empty, last_item, total_sum,
		output ready);
endinterface

@@ rtl/ple_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ple_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ rtl/positional_list_engine_top.sv @@
// Top level of the positional list engine: sequencer, running sum and item store.
//
// Holds an ordered list of up to LIST_DEPTH signed 32-bit items and takes one
// request at a time: insert a value at a 1-based position or remove the item at
// a position. Items move one place per cycle through the item RAM's single read
// and single write port, so an accepted request passes the shift state and then
// a placement or finishing state before its result is presented; removing the final
// item adds a state that fetches the new last item unless it was the only item,
// and a rejected request goes straight to the result state. The request side is
// not ready while a request is in progress. The result waits in an output
// register until taken, and a new request is taken while it waits; a finished
// request holds until that register frees. The running sum is kept by one shared
// add/subtract unit.
module positional_list_engine_top (
	input  logic         clk,
	input  logic         arst_n,
	ple_req_if.sink      req,
	ple_rsp_if.source    rsp
);
	localparam int IdxW     = ple_pkg::IDX_W;
	localparam int CntW     = ple_pkg::CNT_W;
	localparam int CmpW     = ple_pkg::CMP_W;
	localparam int DataW    = ple_pkg::DATA_W;
	localparam int PosW     = ple_pkg::POS_W;
	localparam int CountOutW = ple_pkg::CNT_OUT_W;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_SHIFT = 6'b000010,
		ST_PLACE = 6'b000100,
		ST_FIN   = 6'b001000,
		ST_LAST  = 6'b010000,
		ST_RESP  = 6'b100000
	} state_t;

	state_t            state_q;
	logic              func_q;
	logic [PosW-1:0]   pos_q;
	logic [DataW-1:0]  val_q;
	logic              acc_q;
	logic [CntW-1:0]   cnt_q;
	logic [DataW-1:0]  sum_q;
	logic [DataW-1:0]  last_q;
	logic [IdxW-1:0]   rd_q;
	logic [CntW-1:0]   rd_left_q;
	logic              pend_q;
	logic              pend_gone_q;
	logic [IdxW-1:0]   pend_addr_q;

	logic                 rsp_valid_q;
	logic                 rsp_acc_q;
	logic [CountOutW-1:0] rsp_cnt_q;
	logic                 rsp_empty_q;
	logic [DataW-1:0]     rsp_last_q;
	logic [DataW-1:0]     rsp_sum_q;

	// RAM ports
	logic             mem_we;
	logic [IdxW-1:0]  mem_waddr;
	logic [DataW-1:0] mem_wdata;
	logic [IdxW-1:0]  mem_raddr;
	logic [DataW-1:0] mem_rdata;

	// Request checks
	logic [CmpW-1:0] pos_ext;
	logic [CmpW-1:0] cnt_ext;
	logic [CmpW-1:0] span;
	logic            ins_ok;
	logic            rem_ok;
	logic            req_ok;
	logic            req_fire;

	// Shared add/subtract unit for the running sum
	logic             alu_sub;
	logic [DataW-1:0] alu_b;
	logic [DataW-1:0] alu_sum;

	logic [CmpW-1:0]  pos_q_ext;
	logic             tail_removed;
	logic             rsp_free;

	ple_ram #(
		.WIDTH (DataW),
		.DEPTH (ple_pkg::LIST_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign req_fire = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);

	assign pos_ext = CmpW'(req.position);
	assign cnt_ext = CmpW'(cnt_q);
	assign span    = cnt_ext - pos_ext + CmpW'(1);
	assign ins_ok  = (pos_ext != '0) && (pos_ext <= cnt_ext + CmpW'(1)) &&
		(cnt_ext < CmpW'(ple_pkg::LIST_DEPTH));
	assign rem_ok  = (cnt_ext != '0) && (pos_ext != '0) && (pos_ext <= cnt_ext);
	assign req_ok  = (req.func == ple_pkg::FUNC_INSERT) ? ins_ok : rem_ok;

	assign pos_q_ext    = CmpW'(pos_q);
	assign tail_removed = (pos_q_ext == cnt_ext);

	// Subtract the removed item while its read returns, add the new item on placement.
	assign alu_sub = (state_q == ST_SHIFT);
	assign alu_b   = alu_sub ? ~mem_rdata : val_q;
	assign alu_sum = sum_q + alu_b + DataW'(alu_sub);

	assign rsp_free = !rsp_valid_q || rsp.ready;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = pend_addr_q;
		mem_wdata = mem_rdata;
		mem_raddr = rd_q;
		unique case (state_q)
			ST_SHIFT: begin
				if (pend_q && !pend_gone_q) begin
					mem_we    = 1'b1;
					mem_waddr = (func_q == ple_pkg::FUNC_INSERT) ?
						pend_addr_q + IdxW'(1) : pend_addr_q - IdxW'(1);
				end
			end
			ST_PLACE: begin
				mem_we    = 1'b1;
				mem_waddr = IdxW'(pos_q_ext - CmpW'(1));
				mem_wdata = val_q;
			end
			ST_FIN: begin
				mem_raddr = IdxW'(cnt_ext - CmpW'(2));
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			sum_q       <= '0;
			last_q      <= '0;
			rd_left_q   <= '0;
			pend_q      <= 1'b0;
			pend_gone_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_RESP && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						pend_q <= 1'b0;
						if (req_ok) begin
							rd_left_q <= CntW'(span);
							state_q   <= ST_SHIFT;
						end else begin
							state_q <= ST_RESP;
						end
					end
				end
				ST_SHIFT: begin
					if (pend_q && pend_gone_q) begin
						sum_q <= alu_sum;
					end
					if (rd_left_q != '0) begin
						pend_q      <= 1'b1;
						pend_gone_q <= (func_q == ple_pkg::FUNC_REMOVE) &&
							(CmpW'(rd_q) == pos_q_ext - CmpW'(1));
						rd_left_q   <= rd_left_q - CntW'(1);
					end else begin
						pend_q  <= 1'b0;
						state_q <= (func_q == ple_pkg::FUNC_INSERT) ? ST_PLACE : ST_FIN;
					end
				end
				ST_PLACE: begin
					sum_q <= alu_sum;
					cnt_q <= cnt_q + CntW'(1);
					if (pos_q_ext == cnt_ext + CmpW'(1)) begin
						last_q <= val_q;
					end
					state_q <= ST_RESP;
				end
				ST_FIN: begin
					cnt_q <= cnt_q - CntW'(1);
					priority if (!tail_removed) begin
						state_q <= ST_RESP;
					end else if (cnt_q == CntW'(1)) begin
						last_q  <= '0;
						state_q <= ST_RESP;
					end else begin
						state_q <= ST_LAST;
					end
				end
				ST_LAST: begin
					last_q  <= mem_rdata;
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request fields, read address walk and result payload
	always_ff @(posedge clk) begin
		if (req_fire) begin
			func_q <= req.func;
			pos_q  <= req.position;
			val_q  <= req.value;
			acc_q  <= req_ok;
			rd_q   <= (req.func == ple_pkg::FUNC_INSERT) ?
				IdxW'(cnt_ext - CmpW'(1)) : IdxW'(pos_ext - CmpW'(1));
		end else if (state_q == ST_SHIFT && rd_left_q != '0) begin
			pend_addr_q <= rd_q;
			rd_q        <= (func_q == ple_pkg::FUNC_INSERT) ? rd_q - IdxW'(1) : rd_q + IdxW'(1);
		end
		if (state_q == ST_RESP && rsp_free) begin
			rsp_acc_q   <= acc_q;
			rsp_cnt_q   <= CountOutW'(cnt_q);
			rsp_empty_q <= (cnt_q == '0);
			rsp_last_q  <= last_q;
			rsp_sum_q   <= sum_q;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.accepted   = rsp_acc_q;
	assign rsp.item_count = rsp_cnt_q;
	assign rsp.list_empty = rsp_empty_q;
	assign rsp.last_item  = rsp_last_q;
	assign rsp.total_sum  = rsp_sum_q;

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_ext <= CmpW'(ple_pkg::LIST_DEPTH))
		else $error("item count exceeds list capacity");

	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_empty_q) |-> (rsp_last_q == '0) && (rsp_sum_q == '0))
		else $error("empty list reports a nonzero last item or sum");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (rsp_empty_q == (rsp_cnt_q == '0)))
		else $error("empty flag disagrees with item count");

	assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_SHIFT || state_q == ST_PLACE))
		else $error("item store written outside a shift or placement");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESP && rsp_free) |=> rsp_valid_q && (state_q == ST_IDLE))
		else $error("result not presented after a request finished");
`endif
endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the positional list engine: random and directed requests.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT = 2000;
	localparam int RANDOM_REQUESTS = 800;
	localparam int LONG_HOLD = 80;

	typedef struct {
		logic                              func;
		logic [ple_pkg::POS_W-1:0]         position;
		logic signed [ple_pkg::DATA_W-1:0] value;
		bit                                drain;
	} list_request_t;

	typedef struct {
		logic                              accepted;
		logic [ple_pkg::CNT_OUT_W-1:0]     item_count;
		logic                              list_empty;
		logic signed [ple_pkg::DATA_W-1:0] last_item;
		logic signed [ple_pkg::DATA_W-1:0] total_sum;
	} list_status_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                              req_valid = 1'b0;
	logic                              req_func = ple_pkg::FUNC_INSERT;
	logic [ple_pkg::POS_W-1:0]         req_position = '0;
	logic signed [ple_pkg::DATA_W-1:0] req_value = '0;
	logic                              rsp_ready = 1'b0;

	ple_req_if req();
	ple_rsp_if rsp();

	assign req.valid    = req_valid;
	assign req.func     = req_func;
	assign req.position = req_position;
	assign req.value    = req_value;
	assign rsp.ready    = rsp_ready;

	positional_list_engine_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always #5 clk = ~clk;

	// Predicted list contents, kept in step with accepted requests.
	logic signed [ple_pkg::DATA_W-1:0] list_store [0:ple_pkg::LIST_DEPTH-1];
	int                                held_count = 0;
	logic signed [ple_pkg::DATA_W-1:0] held_sum = '0;

	list_request_t request_queue [$];
	list_status_t  expected_status [$];

	int gen_held = 0;
	int total_requests = 0;
	int sent_count = 0;
	int results_seen = 0;
	int mismatch_count = 0;
	int done_count = 0;
	int rejected_count = 0;
	int full_hits = 0;
	int empty_hits = 0;
	int long_holds = 0;

	function automatic list_status_t apply_list_request(logic func,
		logic [ple_pkg::POS_W-1:0] position, logic signed [ple_pkg::DATA_W-1:0] value);
		list_status_t st;
		int p;
		int i;
		logic signed [ple_pkg::DATA_W-1:0] gone;
		p = position;
		st.accepted = 1'b0;
		if (func == ple_pkg::FUNC_INSERT) begin
			if (p >= 1 && p <= held_count + 1 && held_count < ple_pkg::LIST_DEPTH) begin
				for (i = held_count; i >= p; i--)
					list_store[i] = list_store[i-1];
				list_store[p-1] = value;
				held_count++;
				held_sum += value;
				st.accepted = 1'b1;
				if (held_count == ple_pkg::LIST_DEPTH)
					full_hits++;
			end
		end else begin
			if (held_count > 0 && p >= 1 && p <= held_count) begin
				gone = list_store[p-1];
				for (i = p; i < held_count; i++)
					list_store[i-1] = list_store[i];
				held_count--;
				held_sum -= gone;
				st.accepted = 1'b1;
				if (held_count == 0)
					empty_hits++;
			end
		end
		if (st.accepted)
			done_count++;
		else
			rejected_count++;
		st.item_count = ple_pkg::CNT_OUT_W'(held_count);
		st.list_empty = (held_count == 0);
		st.last_item  = (held_count == 0) ? '0 : list_store[held_count-1];
		st.total_sum  = held_sum;
		return st;
	endfunction

	// Queue one request and track only the item count it leaves behind.
	function automatic void queue_request(logic func, int position,
		logic signed [ple_pkg::DATA_W-1:0] value, bit drain);
		list_request_t item;
		item.func     = func;
		item.position = ple_pkg::POS_W'(position);
		item.value    = value;
		item.drain    = drain;
		request_queue.push_back(item);
		if (func == ple_pkg::FUNC_INSERT) begin
			if (position >= 1 && position <= gen_held + 1 && gen_held < ple_pkg::LIST_DEPTH)
				gen_held++;
		end else if (gen_held > 0 && position >= 1 && position <= gen_held) begin
			gen_held--;
		end
	endfunction

	function automatic logic signed [ple_pkg::DATA_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return '0;
			3: return '1;
			4: return $urandom_range(0, 15);
			default: return $urandom;
		endcase
	endfunction

	// Position at or next to the ends of the list three times in ten, else uniform over the range.
	function automatic int pick_position(int lo, int hi);
		case ($urandom_range(0, 9))
			0: return lo;
			1: return hi;
			2: return (hi > lo) ? hi - 1 : hi;
			default: return $urandom_range(lo, hi);
		endcase
	endfunction

	task automatic report_mismatch(string what, logic [ple_pkg::DATA_W-1:0] got,
		logic [ple_pkg::DATA_W-1:0] want);
		if (mismatch_count < 30)
			$display("mismatch at result %0d: %s got %h want %h", results_seen, what, got, want);
		mismatch_count++;
	endtask

	// Sender: bursts of random length with random gaps, holding an item until taken.
	int gap_left = 0;
	int burst_left = 1;
	bit req_fire;
	list_request_t next_item;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			req_fire = req_valid && req.ready;
			if (!req_valid || req_fire) begin
				if (gap_left > 0) begin
					gap_left--;
					req_valid <= 1'b0;
				end else if (request_queue.size() == 0 ||
					(request_queue[0].drain && (expected_status.size() != 0 || req_fire))) begin
					req_valid <= 1'b0;
				end else begin
					next_item = request_queue.pop_front();
					req_valid    <= 1'b1;
					req_func     <= next_item.func;
					req_position <= next_item.position;
					req_value    <= next_item.value;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
							: $urandom_range(1, 12);
						gap_left = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 20)
							: $urandom_range(1, 6);
					end
				end
			end
		end
	end

	// Receiver: a repeating stall pattern that is picked anew at each phase, plus long hold-offs.
	logic [15:0] stall_pattern = '1;
	int phase_left = 0;
	int hold_left = 0;
	int next_hold_at = 60;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			rsp_ready <= 1'b0;
		end else if (results_seen >= next_hold_at) begin
			hold_left = LONG_HOLD;
			next_hold_at += 400;
			long_holds++;
			rsp_ready <= 1'b0;
		end else begin
			if (phase_left == 0) begin
				case ($urandom_range(0, 3))
					0, 1: stall_pattern = '1;
					2: stall_pattern = 16'($urandom);
					default: stall_pattern = 16'h8421;
				endcase
				if (stall_pattern == '0)
					stall_pattern = 16'h0001;
				phase_left = 64;
			end
			phase_left--;
			rsp_ready <= stall_pattern[phase_left % 16];
		end
	end

	// Monitor: check each result against the oldest prediction, then predict new requests.
	list_status_t want;

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp.valid && rsp_ready) begin
				results_seen++;
				if (expected_status.size() == 0) begin
					report_mismatch("result with nothing outstanding",
						ple_pkg::DATA_W'(rsp.item_count), '0);
				end else begin
					want = expected_status.pop_front();
					if (rsp.accepted !== want.accepted)
						report_mismatch("accepted", ple_pkg::DATA_W'(rsp.accepted),
							ple_pkg::DATA_W'(want.accepted));
					if (rsp.item_count !== want.item_count)
						report_mismatch("item_count", ple_pkg::DATA_W'(rsp.item_count),
							ple_pkg::DATA_W'(want.item_count));
					if (rsp.list_empty !== want.list_empty)
						report_mismatch("list_empty", ple_pkg::DATA_W'(rsp.list_empty),
							ple_pkg::DATA_W'(want.list_empty));
					if (rsp.last_item !== want.last_item)
						report_mismatch("last_item", rsp.last_item, want.last_item);
					if (rsp.total_sum !== want.total_sum)
						report_mismatch("total_sum", rsp.total_sum, want.total_sum);
				end
			end
			if (req_valid && req.ready) begin
				expected_status.push_back(apply_list_request(req_func, req_position, req_value));
				sent_count++;
			end
		end
	end

	// Watchdog on cycles in which neither channel moves an item.
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || (req_valid && req.ready) || (rsp.valid && rsp_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout: %0d requests sent, %0d results outstanding", sent_count,
				expected_status.size());
			$display("status: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	int insert_weight;
	bit noise;
	bit do_insert;

	initial begin
		// Empty-list corner cases.
		queue_request(ple_pkg::FUNC_REMOVE, 1, '0, 0);
		queue_request(ple_pkg::FUNC_INSERT, 0, 32'h1234_5678, 0);
		queue_request(ple_pkg::FUNC_INSERT, 2, 32'h1234_5678, 0);
		// Sum overflow and value extremes.
		queue_request(ple_pkg::FUNC_INSERT, 1, 32'h7FFF_FFFF, 0);
		queue_request(ple_pkg::FUNC_INSERT, 2, 32'h7FFF_FFFF, 0);
		queue_request(ple_pkg::FUNC_INSERT, 1, 32'h8000_0000, 0);
		queue_request(ple_pkg::FUNC_INSERT, 4, '1, 0);
		queue_request(ple_pkg::FUNC_INSERT, 3, '0, 0);
		// Out-of-range positions on a partly filled list.
		queue_request(ple_pkg::FUNC_REMOVE, 0, '1, 0);
		queue_request(ple_pkg::FUNC_REMOVE, gen_held + 1, '0, 0);
		queue_request(ple_pkg::FUNC_REMOVE, 31, '0, 0);
		queue_request(ple_pkg::FUNC_INSERT, 31, '1, 0);
		// Fill to capacity, then try once more at both ends.
		while (gen_held < ple_pkg::LIST_DEPTH)
			queue_request(ple_pkg::FUNC_INSERT, $urandom_range(1, gen_held + 1), pick_value(), 0);
		queue_request(ple_pkg::FUNC_INSERT, 1, 32'h5555_5555, 0);
		queue_request(ple_pkg::FUNC_INSERT, ple_pkg::LIST_DEPTH + 1, 32'hAAAA_AAAA, 0);
		// Remove the last, the first and a middle item.
		queue_request(ple_pkg::FUNC_REMOVE, gen_held, '0, 0);
		queue_request(ple_pkg::FUNC_REMOVE, 1, '0, 0);
		queue_request(ple_pkg::FUNC_REMOVE, gen_held / 2, '0, 0);

		insert_weight = 50;
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			// Shift the insert/remove balance so the list sweeps between empty and full.
			if (n % 100 == 0)
				insert_weight = $urandom_range(0, 1) ? $urandom_range(70, 95)
					: $urandom_range(5, 30);
			noise = ($urandom_range(0, 9) == 0);
			if (noise) begin
				queue_request(1'($urandom_range(0, 1)), $urandom_range(0, 31), pick_value(),
					n % 200 == 0);
			end else begin
				do_insert = ($urandom_range(1, 100) <= insert_weight);
				if (gen_held == ple_pkg::LIST_DEPTH)
					do_insert = 1'b0;
				if (gen_held == 0)
					do_insert = 1'b1;
				if (do_insert)
					queue_request(ple_pkg::FUNC_INSERT, pick_position(1, gen_held + 1),
						pick_value(), n % 200 == 0);
				else
					queue_request(ple_pkg::FUNC_REMOVE, pick_position(1, gen_held),
						pick_value(), n % 200 == 0);
			end
		end
		total_requests = request_queue.size();

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (sent_count < total_requests || expected_status.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);

		$display("ran %0d requests: %0d carried out, %0d rejected, %0d results checked",
			sent_count, done_count, rejected_count, results_seen);
		$display("list filled %0d times, emptied %0d times, %0d long result hold-offs",
			full_hits, empty_hits, long_holds);
		if (mismatch_count == 0 && expected_status.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("status: fail");
		end
		$finish;
	end

endmodule
